@@ rtl/core/cpio_newc_archive_parser_macros.svh @@
// Assertion macros used by the parser top level.
`ifndef CPIO_NEWC_ARCHIVE_PARSER_MACROS_SVH
`define CPIO_NEWC_ARCHIVE_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is high.
`define CNAP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cnap assertion failed");
// Checked property, also active during reset.
`define CNAP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("cnap assertion failed");
`else
`define CNAP_ASSERT(lbl, clk, rst, prop)
`define CNAP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/core/cnap_pkg.sv @@
// Types, constants and helper functions of the newc cpio parser.
package cnap_pkg;

   localparam int unsigned HDR_LEN = 110;

   localparam logic [31:0] TYPE_MASK = 32'o0170000;
   localparam logic [31:0] TYPE_DIR  = 32'o0040000;
   localparam logic [31:0] TYPE_LNK  = 32'o0120000;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_NAME    = 3'd1,
      PH_NAMEPAD = 3'd2,
      PH_DATA    = 3'd3,
      PH_DATAPAD = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_ENTRY     = 3'd0,
      ST_CLEAN_END = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_TRUNC_NAME = 3'd3,
      ST_TRUNC_FILE = 3'd4,
      ST_TABLE_FULL = 3'd5,
      ST_TOO_SMALL = 3'd6
   } status_type;

   // One result item without its run_last flag.
   typedef struct packed {
      status_type  status;
      logic [5:0]  entry_index;
      logic [31:0] file_mode;
      logic [31:0] link_count;
      logic [31:0] file_size;
      logic [31:0] data_offset;
      logic [31:0] name_offset;
      logic [31:0] name_length;
      logic        is_directory;
      logic        is_link;
   } result_type;

   // Results caused by one input byte, in order.
   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } pkt_type;

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      begin
         t = 8'd0;
         if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
         else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
         else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
         return t[3:0];
      end
   endfunction

   // "070701"
   function automatic logic [7:0] magic_char(input logic [2:0] k);
      logic [7:0] c;
      begin
         case (k)
            3'd0, 3'd2, 3'd4: c = 8'h30;
            3'd1, 3'd3:       c = 8'h37;
            3'd5:             c = 8'h31;
            default:          c = 8'h00;
         endcase
         return c;
      end
   endfunction

   // "TRAILER!!!"
   function automatic logic [7:0] trailer_char(input logic [3:0] i);
      logic [7:0] c;
      begin
         case (i)
            4'd0: c = 8'h54;
            4'd1: c = 8'h52;
            4'd2: c = 8'h41;
            4'd3: c = 8'h49;
            4'd4: c = 8'h4C;
            4'd5: c = 8'h45;
            4'd6: c = 8'h52;
            4'd7, 4'd8, 4'd9: c = 8'h21;
            default: c = 8'h00;
         endcase
         return c;
      end
   endfunction

   // Name candidates: empty, ".", "..", trailer.
   function automatic logic [3:0] cand_len(input logic [1:0] k);
      logic [3:0] l;
      begin
         case (k)
            2'd0: l = 4'd0;
            2'd1: l = 4'd1;
            2'd2: l = 4'd2;
            default: l = 4'd10;
         endcase
         return l;
      end
   endfunction

   function automatic logic [7:0] cand_byte(input logic [1:0] k, input logic [3:0] i);
      logic [7:0] c;
      begin
         case (k)
            2'd1, 2'd2: c = 8'h2E;
            2'd3: c = trailer_char(i);
            default: c = 8'h00;
         endcase
         return c;
      end
   endfunction

endpackage

@@ rtl/core/cnap_if.sv @@
// Channel interfaces of the parser: byte input, results, capacity register.
interface cnap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_end;
   modport source (output valid, data_byte, image_end, input ready);
   modport sink   (input valid, data_byte, image_end, output ready);
endinterface

interface cnap_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  entry_index;
   logic [31:0] file_mode;
   logic [31:0] link_count;
   logic [31:0] file_size;
   logic [31:0] data_offset;
   logic [31:0] name_offset;
   logic [31:0] name_length;
   logic        is_directory;
   logic        is_link;
   logic        run_last;
   modport source (output valid, status, entry_index, file_mode, link_count, file_size,
                   data_offset, name_offset, name_length, is_directory, is_link,
                   run_last, input ready);
   modport sink   (input valid, status, entry_index, file_mode, link_count, file_size,
                   data_offset, name_offset, name_length, is_directory, is_link,
                   run_last, output ready);
endinterface

interface cnap_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] max_entries;
   modport source (output valid, max_entries, input ready);
   modport sink   (input valid, max_entries, output ready);
endinterface

@@ rtl/core/cnap_front.sv @@
// Front end: consumes image bytes, walks the header/name/data regions, builds results.
module cnap_front #(
   parameter int unsigned MAX_TABLE   = 64,
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic [6:0]           max_entries,
   output logic                 pkt_push,
   output cnap_pkg::pkt_type    pkt
);

   cnap_pkg::phase_type    phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            rc_ff, rc_in;
   logic                   mg_ff, mg_in;
   logic [31:0]            mode_ff, mode_in, nlink_ff, nlink_in;
   logic [31:0]            size_ff, size_in, ns_ff, ns_in;
   logic [3:0]             nm_ff, nm_in;
   logic                   ne_ff, ne_in;
   logic [6:0]             used_ff, used_in;
   logic                   halt_ff, halt_in;
   logic [OFFSET_BITS-1:0] nstart_ff, nstart_in, dstart_ff, dstart_in;
   logic                   hdone_ff, hdone_in;

   logic                   put_e, put_s, stop, keep;
   cnap_pkg::status_type   st;
   cnap_pkg::result_type   er, sr;
   logic [31:0]            idx;
   logic [3:0]             d;
   logic [8:0]             cap;
   logic [1:0]             pad;

   localparam logic [8:0] TableCap = 9'(MAX_TABLE);

   // Per-byte parse step
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      rc_in     = rc_ff;
      mg_in     = mg_ff;
      mode_in   = mode_ff;
      nlink_in  = nlink_ff;
      size_in   = size_ff;
      ns_in     = ns_ff;
      nm_in     = nm_ff;
      ne_in     = ne_ff;
      used_in   = used_ff;
      halt_in   = halt_ff;
      nstart_in = nstart_ff;
      dstart_in = dstart_ff;
      hdone_in  = hdone_ff;
      put_e = 1'b0;
      put_s = 1'b0;
      stop  = 1'b0;
      keep  = 1'b0;
      st    = cnap_pkg::ST_ENTRY;
      er    = '0;
      idx   = 32'd0;
      d     = cnap_pkg::hex_val(in_byte);
      cap   = ({2'b00, max_entries} < TableCap) ? {2'b00, max_entries} : TableCap;
      pad   = 2'd0;

      if (!halt_ff) begin
         // consume the byte
         if (phase_in == cnap_pkg::PH_HEADER) begin
            if (rc_in < 32'd6 && in_byte != cnap_pkg::magic_char(rc_in[2:0])) mg_in = 1'b0;
            if (rc_in >= 32'd14 && rc_in < 32'd22) mode_in = {mode_in[27:0], d};
            if (rc_in >= 32'd38 && rc_in < 32'd46) nlink_in = {nlink_in[27:0], d};
            if (rc_in >= 32'd54 && rc_in < 32'd62) size_in = {size_in[27:0], d};
            if (rc_in >= 32'd94 && rc_in < 32'd102) ns_in = {ns_in[27:0], d};
            rc_in = rc_in + 32'd1;
         end else begin
            if (phase_in == cnap_pkg::PH_NAME && !ne_in) begin
               idx = ns_in - rc_in;
               for (int k = 0; k < 4; k++) begin
                  if (idx < {28'd0, cnap_pkg::cand_len(2'(k))})
                     keep = (in_byte == cnap_pkg::cand_byte(2'(k), idx[3:0]));
                  else if (idx == {28'd0, cnap_pkg::cand_len(2'(k))})
                     keep = (in_byte == 8'd0);
                  else
                     keep = 1'b0;
                  if (!keep) nm_in[k] = 1'b0;
               end
               if (in_byte == 8'd0) ne_in = 1'b1;
            end
            rc_in = rc_in - 32'd1;
         end
         pos_in = pos_in + OFFSET_BITS'(1);

         // header complete
         if (phase_in == cnap_pkg::PH_HEADER) begin
            if (rc_in < 32'(cnap_pkg::HDR_LEN)) begin
               stop = 1'b1;
            end else begin
               hdone_in = 1'b1;
               if (!mg_in) begin
                  put_s = 1'b1; st = cnap_pkg::ST_BAD_MAGIC; halt_in = 1'b1; stop = 1'b1;
               end else begin
                  nstart_in = pos_in;
                  rc_in     = ns_in;
                  nm_in     = 4'hF;
                  ne_in     = 1'b0;
                  phase_in  = cnap_pkg::PH_NAME;
               end
            end
         end
         // end of name
         if (!stop && phase_in == cnap_pkg::PH_NAME && rc_in == 32'd0) begin
            if (!ne_in)
               for (int k = 0; k < 4; k++)
                  if (ns_in != {28'd0, cnap_pkg::cand_len(2'(k))}) nm_in[k] = 1'b0;
            if (nm_in[3]) begin
               put_s = 1'b1; st = cnap_pkg::ST_CLEAN_END; halt_in = 1'b1; stop = 1'b1;
            end else begin
               pad      = 2'(2'd0 - (ns_in[1:0] + 2'd2));
               rc_in    = {30'd0, pad};
               phase_in = cnap_pkg::PH_NAMEPAD;
            end
         end
         // end of name padding
         if (!stop && phase_in == cnap_pkg::PH_NAMEPAD && rc_in == 32'd0) begin
            dstart_in = pos_in;
            rc_in     = size_in;
            phase_in  = cnap_pkg::PH_DATA;
         end
         // end of data: report the entry or table full; skip "", "." and ".."
         if (!stop && phase_in == cnap_pkg::PH_DATA && rc_in == 32'd0) begin
            if (nm_in[2:0] == 3'd0) begin
               if ({2'b00, used_in} >= cap) begin
                  put_s = 1'b1; st = cnap_pkg::ST_TABLE_FULL; halt_in = 1'b1; stop = 1'b1;
               end else begin
                  put_e           = 1'b1;
                  er.status       = cnap_pkg::ST_ENTRY;
                  er.entry_index  = used_in[5:0];
                  er.file_mode    = mode_in;
                  er.link_count   = nlink_in;
                  er.file_size    = size_in;
                  er.data_offset  = 32'(dstart_in);
                  er.name_offset  = 32'(nstart_in);
                  er.name_length  = ns_in;
                  er.is_directory = (mode_in & cnap_pkg::TYPE_MASK) == cnap_pkg::TYPE_DIR;
                  er.is_link      = (mode_in & cnap_pkg::TYPE_MASK) == cnap_pkg::TYPE_LNK;
                  used_in         = used_in + 7'd1;
               end
            end
            if (!stop) begin
               pad      = 2'(2'd0 - size_in[1:0]);
               rc_in    = {30'd0, pad};
               phase_in = cnap_pkg::PH_DATAPAD;
            end
         end
         // end of data padding: next header
         if (!stop && phase_in == cnap_pkg::PH_DATAPAD && rc_in == 32'd0) begin
            phase_in = cnap_pkg::PH_HEADER;
            rc_in    = 32'd0;
            mg_in    = 1'b1;
            mode_in  = 32'd0;
            nlink_in = 32'd0;
            size_in  = 32'd0;
            ns_in    = 32'd0;
         end
         // end of image status
         if (in_last && !halt_in) begin
            put_s = 1'b1;
            case (phase_in)
               cnap_pkg::PH_HEADER:
                  st = hdone_in ? cnap_pkg::ST_CLEAN_END : cnap_pkg::ST_TOO_SMALL;
               cnap_pkg::PH_NAME:    st = cnap_pkg::ST_TRUNC_NAME;
               cnap_pkg::PH_DATAPAD: st = cnap_pkg::ST_CLEAN_END;
               default:              st = cnap_pkg::ST_TRUNC_FILE;
            endcase
         end
      end

      // last byte re-arms for a new image
      if (in_last) begin
         phase_in = cnap_pkg::PH_HEADER;
         pos_in = '0; rc_in = 32'd0; mg_in = 1'b1;
         mode_in = 32'd0; nlink_in = 32'd0; size_in = 32'd0; ns_in = 32'd0;
         nm_in = 4'hF; ne_in = 1'b0; used_in = 7'd0; halt_in = 1'b0;
         nstart_in = '0; dstart_in = '0; hdone_in = 1'b0;
      end
   end

   // Pack results of this byte
   always_comb begin
      sr        = '0;
      sr.status = st;
      pkt.cnt   = {1'b0, put_e} + {1'b0, put_s};
      pkt.r0    = put_e ? er : sr;
      pkt.r1    = sr;
      pkt_push  = in_take && (put_e || put_s);
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cnap_pkg::PH_HEADER;
         pos_ff <= '0; rc_ff <= 32'd0; mg_ff <= 1'b1;
         mode_ff <= 32'd0; nlink_ff <= 32'd0; size_ff <= 32'd0; ns_ff <= 32'd0;
         nm_ff <= 4'hF; ne_ff <= 1'b0; used_ff <= 7'd0; halt_ff <= 1'b0;
         nstart_ff <= '0; dstart_ff <= '0; hdone_ff <= 1'b0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in; rc_ff <= rc_in; mg_ff <= mg_in;
         mode_ff <= mode_in; nlink_ff <= nlink_in; size_ff <= size_in; ns_ff <= ns_in;
         nm_ff <= nm_in; ne_ff <= ne_in; used_ff <= used_in; halt_ff <= halt_in;
         nstart_ff <= nstart_in; dstart_ff <= dstart_in; hdone_ff <= hdone_in;
      end
   end

endmodule

@@ rtl/core/cnap_queue.sv @@
// Two-deep queue of per-byte result packets between front and back.
module cnap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cnap_pkg::pkt_type push_pkt,
   output logic              has_room,
   input  logic              pop,
   output logic              not_empty,
   output cnap_pkg::pkt_type head
);

   cnap_pkg::pkt_type mem_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;

   assign has_room  = cnt_ff != 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rp_ff];

   // Pointers and fill count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Packet storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_pkt;
   end

endmodule

@@ rtl/core/cnap_back.sv @@
// Back end: splits packets into single result items behind an output register.
module cnap_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  cnap_pkg::pkt_type q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output cnap_pkg::result_type out_res,
   output logic              out_last
);

   logic                 v_ff, v_in, last_ff, last_in, p2_ff, p2_in;
   cnap_pkg::result_type res_ff, res_in, r1_ff, r1_in;
   logic                 free;

   assign out_valid = v_ff;
   assign out_res   = res_ff;
   assign out_last  = last_ff;

   // Load the output register when it empties
   always_comb begin
      free    = !v_ff || out_ready;
      v_in    = v_ff;
      last_in = last_ff;
      p2_in   = p2_ff;
      res_in  = res_ff;
      r1_in   = r1_ff;
      q_pop   = 1'b0;
      if (free) begin
         if (p2_ff) begin
            v_in = 1'b1; res_in = r1_ff; last_in = 1'b1; p2_in = 1'b0;
         end else if (q_not_empty) begin
            q_pop   = 1'b1;
            v_in    = 1'b1;
            res_in  = q_head.r0;
            last_in = q_head.cnt != 2'd2;
            p2_in   = q_head.cnt == 2'd2;
            r1_in   = q_head.r1;
         end else begin
            v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         v_ff  <= v_in;
         p2_ff <= p2_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      r1_ff   <= r1_in;
      last_ff <= last_in;
   end

endmodule

@@ rtl/core/cpio_newc_archive_parser.sv @@
// Top level of the streaming newc cpio archive parser.
// req: one image byte per item, image_end marks the last byte of an image.
// rsp: result items (entry reports and end or error status), run_last set on
//   the last result caused by one byte.
// csr: writes the entry table capacity; always ready, use only while idle.
// A byte is parsed in the cycle it is accepted, one byte per cycle while
// req.ready is high. Its results pass through the queue and then the rsp
// register; two results of one byte leave that register in turn.
// A two-packet queue sits between the parser and the output register, so
// req keeps flowing while rsp is stalled until the queue is full; then
// req.ready drops.
// After the trailer or an error, bytes are swallowed until image_end.
// Reset clears the parser to the start of an image, empties the queue and
// sets the capacity to 64.
`include "cpio_newc_archive_parser_macros.svh"
module cpio_newc_archive_parser #(
   parameter int unsigned MAX_TABLE   = 64,
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   cnap_req_if.sink    req,
   cnap_rsp_if.source  rsp,
   cnap_csr_if.sink    csr
);

   logic                 max_ff;
   logic [6:0]           cap_ff;
   logic                 take, push, room, pop, ne;
   cnap_pkg::pkt_type    pkt, head;
   cnap_pkg::result_type res;

   // Capacity register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 7'd64;
         max_ff <= 1'b0;
      end else begin
         if (csr.valid) cap_ff <= csr.max_entries;
         max_ff <= 1'b1;
      end
   end

   assign req.ready = room && max_ff;
   assign take      = req.valid && req.ready;

   cnap_front #(.MAX_TABLE(MAX_TABLE), .OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock(clock), .reset(reset), .in_take(take), .in_byte(req.data_byte),
      .in_last(req.image_end), .max_entries(cap_ff), .pkt_push(push), .pkt(pkt)
   );

   cnap_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_pkt(pkt), .has_room(room),
      .pop(pop), .not_empty(ne), .head(head)
   );

   cnap_back u_back (
      .clock(clock), .reset(reset), .q_not_empty(ne), .q_head(head), .q_pop(pop),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res), .out_last(rsp.run_last)
   );

   assign rsp.status       = res.status;
   assign rsp.entry_index  = res.entry_index;
   assign rsp.file_mode    = res.file_mode;
   assign rsp.link_count   = res.link_count;
   assign rsp.file_size    = res.file_size;
   assign rsp.data_offset  = res.data_offset;
   assign rsp.name_offset  = res.name_offset;
   assign rsp.name_length  = res.name_length;
   assign rsp.is_directory = res.is_directory;
   assign rsp.is_link      = res.is_link;

   // Checks
   `CNAP_ASSERT(a_status_zero, clock, reset, rsp.valid && rsp.status != cnap_pkg::ST_ENTRY |-> rsp.file_mode == 32'd0 && rsp.entry_index == 6'd0 && rsp.name_length == 32'd0)
   `CNAP_ASSERT(a_type_excl, clock, reset, rsp.valid |-> !(rsp.is_directory && rsp.is_link))
   `CNAP_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp.valid)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the newc cpio archive parser: directed images, then random ones.
module testbench;

   // One expected result item with its end-of-byte flag.
   typedef struct {
      cnap_pkg::result_type r;
      logic                 last;
   } outcome_type;

   // One directed image: a single entry, an optional trailer, garbage and a cut.
   typedef struct {
      string       nm;
      int          nsz;
      logic [31:0] mode;
      logic [31:0] size;
      int          body;
      bit          badmag;
      bit          trl;
      int          tail;
      int          keep;
      int          want;
   } image_row_type;

   localparam logic [31:0] M_REG = 32'o100644;
   localparam logic [31:0] M_DIR = 32'o040755;
   localparam logic [31:0] M_LNK = 32'o120777;
   localparam int          NONE  = -1;

   logic clock;
   logic reset;

   cnap_req_if req ();
   cnap_rsp_if rsp ();
   cnap_csr_if csr ();

   cpio_newc_archive_parser dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #5 clock = ~clock;

   // Parser state mirrored by the predictor
   cnap_pkg::phase_type ph;
   logic [31:0] pos, rcnt, mode_a, nlink_a, size_a, nsz_a, name_st, data_st;
   logic        magic_ok, nm_ended, stopped, hdr_seen;
   logic [3:0]  nm_match;
   logic [6:0]  used;
   logic [6:0]  capacity;

   outcome_type pending[$];
   logic [7:0]  img[$];
   int          errors, bytes_sent, images_sent, entries_seen, results_seen;
   int          img_last_status;
   bit          quiet, hold_req;

   task automatic report(input string f, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", f, got, exp, $realtime);
      errors++;
   endtask

   function automatic logic [3:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
   endfunction

   task automatic start_image();
      ph = cnap_pkg::PH_HEADER;
      pos = 0; rcnt = 0; magic_ok = 1;
      mode_a = 0; nlink_a = 0; size_a = 0; nsz_a = 0;
      nm_match = 4'hF; nm_ended = 0; used = 0; stopped = 0;
      name_st = 0; data_st = 0; hdr_seen = 0;
   endtask

   task automatic emit(input cnap_pkg::status_type st, input bit entry,
                       inout outcome_type q[$]);
      outcome_type o;
      o.r = '0;
      o.last = 0;
      o.r.status = st;
      if (entry) begin
         o.r.entry_index  = used[5:0];
         o.r.file_mode    = mode_a;
         o.r.link_count   = nlink_a;
         o.r.file_size    = size_a;
         o.r.data_offset  = data_st;
         o.r.name_offset  = name_st;
         o.r.name_length  = nsz_a;
         o.r.is_directory = (mode_a & cnap_pkg::TYPE_MASK) == cnap_pkg::TYPE_DIR;
         o.r.is_link      = (mode_a & cnap_pkg::TYPE_MASK) == cnap_pkg::TYPE_LNK;
      end
      if (q.size() < 2) q.push_back(o);
      img_last_status = st;
   endtask

   // Expected results of one accepted byte
   task automatic parse_byte(input logic [7:0] b, input logic last);
      outcome_type q[$];
      logic [31:0] i, clen, eff;
      logic [7:0]  cb;
      string       trl, mg;
      bit          keep, busy;
      trl = "TRAILER!!!";
      mg  = "070701";
      if (!stopped) begin
         // absorb the byte
         if (ph == cnap_pkg::PH_HEADER) begin
            if (rcnt < 6 && b != mg[rcnt]) magic_ok = 0;
            if (rcnt >= 14 && rcnt < 22) mode_a = {mode_a[27:0], digit_of(b)};
            if (rcnt >= 38 && rcnt < 46) nlink_a = {nlink_a[27:0], digit_of(b)};
            if (rcnt >= 54 && rcnt < 62) size_a = {size_a[27:0], digit_of(b)};
            if (rcnt >= 94 && rcnt < 102) nsz_a = {nsz_a[27:0], digit_of(b)};
            rcnt++;
         end else begin
            if (ph == cnap_pkg::PH_NAME && !nm_ended) begin
               i = nsz_a - rcnt;
               for (int k = 0; k < 4; k++) begin
                  clen = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 2 : 10;
                  cb = (k == 1 || k == 2) ? "." : (k == 3 && i < 10) ? trl[i] : 8'd0;
                  if (i < clen) keep = (b == cb);
                  else if (i == clen) keep = (b == 0);
                  else keep = 0;
                  if (!keep) nm_match[k] = 0;
               end
               if (b == 0) nm_ended = 1;
            end
            rcnt--;
         end
         pos++;
         // advance through regions that are complete
         busy = 1;
         while (busy) begin
            if (ph == cnap_pkg::PH_HEADER) begin
               if (rcnt < cnap_pkg::HDR_LEN) busy = 0;
               else begin
                  hdr_seen = 1;
                  if (!magic_ok) begin
                     emit(cnap_pkg::ST_BAD_MAGIC, 0, q); stopped = 1; busy = 0;
                  end else begin
                     name_st = pos; rcnt = nsz_a; nm_match = 4'hF; nm_ended = 0;
                     ph = cnap_pkg::PH_NAME;
                  end
               end
            end else if (rcnt != 0) begin
               busy = 0;
            end else if (ph == cnap_pkg::PH_NAME) begin
               if (!nm_ended) begin
                  if (nsz_a != 0) nm_match[0] = 0;
                  if (nsz_a != 1) nm_match[1] = 0;
                  if (nsz_a != 2) nm_match[2] = 0;
                  if (nsz_a != 10) nm_match[3] = 0;
               end
               if (nm_match[3]) begin
                  emit(cnap_pkg::ST_CLEAN_END, 0, q); stopped = 1; busy = 0;
               end else begin
                  rcnt = (4 - ((nsz_a + cnap_pkg::HDR_LEN) & 3)) & 3;
                  ph = cnap_pkg::PH_NAMEPAD;
               end
            end else if (ph == cnap_pkg::PH_NAMEPAD) begin
               data_st = pos; rcnt = size_a; ph = cnap_pkg::PH_DATA;
            end else if (ph == cnap_pkg::PH_DATA) begin
               if (nm_match[2:0] == 0) begin
                  eff = (capacity < 64) ? capacity : 64;
                  if (used >= eff) begin
                     emit(cnap_pkg::ST_TABLE_FULL, 0, q); stopped = 1;
                  end else begin
                     emit(cnap_pkg::ST_ENTRY, 1, q); used++;
                  end
               end
               if (!stopped) begin
                  rcnt = (4 - (size_a & 3)) & 3;
                  ph = cnap_pkg::PH_DATAPAD;
               end else busy = 0;
            end else begin
               ph = cnap_pkg::PH_HEADER; rcnt = 0; magic_ok = 1;
               mode_a = 0; nlink_a = 0; size_a = 0; nsz_a = 0;
               busy = 0;
            end
         end
         // the image ends here
         if (last && !stopped) begin
            if (ph == cnap_pkg::PH_HEADER)
               emit(hdr_seen ? cnap_pkg::ST_CLEAN_END : cnap_pkg::ST_TOO_SMALL, 0, q);
            else if (ph == cnap_pkg::PH_NAME) emit(cnap_pkg::ST_TRUNC_NAME, 0, q);
            else if (ph == cnap_pkg::PH_DATAPAD) emit(cnap_pkg::ST_CLEAN_END, 0, q);
            else emit(cnap_pkg::ST_TRUNC_FILE, 0, q);
         end
      end
      if (last) start_image();
      if (q.size() > 0) q[q.size() - 1].last = 1;
      foreach (q[k]) pending.push_back(q[k]);
   endtask

   // Accepted items on all three channels
   always @(posedge clock) begin
      outcome_type o;
      if (!reset) begin
         if (csr.valid && csr.ready) capacity <= csr.max_entries;
         if (req.valid && req.ready) parse_byte(req.data_byte, req.image_end);
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (rsp.status == cnap_pkg::ST_ENTRY) entries_seen++;
            if (pending.size() == 0) begin
               $display("unexpected result, status %0d, at %0t", rsp.status, $realtime);
               errors++;
            end else begin
               o = pending.pop_front();
               if (rsp.status != o.r.status) report("status", rsp.status, o.r.status);
               if (rsp.entry_index != o.r.entry_index)
                  report("entry_index", rsp.entry_index, o.r.entry_index);
               if (rsp.file_mode != o.r.file_mode)
                  report("file_mode", rsp.file_mode, o.r.file_mode);
               if (rsp.link_count != o.r.link_count)
                  report("link_count", rsp.link_count, o.r.link_count);
               if (rsp.file_size != o.r.file_size)
                  report("file_size", rsp.file_size, o.r.file_size);
               if (rsp.data_offset != o.r.data_offset)
                  report("data_offset", rsp.data_offset, o.r.data_offset);
               if (rsp.name_offset != o.r.name_offset)
                  report("name_offset", rsp.name_offset, o.r.name_offset);
               if (rsp.name_length != o.r.name_length)
                  report("name_length", rsp.name_length, o.r.name_length);
               if (rsp.is_directory != o.r.is_directory)
                  report("is_directory", rsp.is_directory, o.r.is_directory);
               if (rsp.is_link != o.r.is_link) report("is_link", rsp.is_link, o.r.is_link);
               if (rsp.run_last != o.last) report("run_last", rsp.run_last, o.last);
            end
         end
      end
   end

   // Result side: random stalls, one long hold-off on request
   initial begin
      int w;
      rsp.ready = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp.ready <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else begin
            w = quiet ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
               rsp.ready <= 0;
               repeat (w) @(posedge clock);
            end
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // Hex text of one header field, optionally with stray random bytes in place of digits
   task automatic add_field(input logic [31:0] v, input bit noisy);
      logic [3:0] nib;
      logic [7:0] c;
      for (int d = 7; d >= 0; d--) begin
         nib = v[4*d +: 4];
         if (nib < 10) c = "0" + nib;
         else c = ($urandom_range(0, 1) ? "a" : "A") + nib - 10;
         if (noisy && $urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
         img.push_back(c);
      end
   endtask

   task automatic add_entry(input logic [31:0] mode, input logic [31:0] size, input string nm,
                            input int nsz, input bit badmag, input bit noisy, input int body);
      logic [31:0] v;
      string       mg;
      int          p;
      mg = "070701";
      for (int k = 0; k < 6; k++) img.push_back(mg[k]);
      if (badmag) begin
         p = img.size() - 6 + $urandom_range(0, 5);
         img[p] = img[p] ^ 8'($urandom_range(1, 255));
      end
      for (int f = 0; f < 13; f++) begin
         v = $urandom;
         if (f == 1) v = mode;
         if (f == 4 && $urandom_range(0, 1)) v = 1;
         if (f == 6) v = size;
         if (f == 11) v = nsz;
         add_field(v, noisy && f != 6 && f != 11);
      end
      for (int k = 0; k < nsz; k++)
         img.push_back(k < nm.len() ? nm[k] : (k == nm.len() ? 8'd0 : 8'($urandom_range(0, 255))));
      repeat ((4 - ((cnap_pkg::HDR_LEN + nsz) & 3)) & 3) img.push_back(8'd0);
      repeat (body) img.push_back(8'($urandom_range(0, 255)));
      repeat ((4 - (size & 3)) & 3) img.push_back(8'd0);
   endtask

   task automatic send_image(input int keep);
      int w;
      if (keep > 0 && keep < img.size()) img = img[0:keep-1];
      images_sent++;
      foreach (img[k]) begin
         w = quiet ? 0 : $urandom_range(0, 4);
         if (w > 0) begin
            req.valid <= 0;
            repeat (w) @(posedge clock);
         end
         req.valid     <= 1;
         req.data_byte <= img[k];
         req.image_end <= (k == img.size() - 1);
         do @(posedge clock); while (!req.ready);
         bytes_sent++;
      end
      img.delete();
   endtask

   // Quiet point: every result in, then a wait for work still in flight
   task automatic settle_down();
      req.valid <= 0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] v);
      csr.valid       <= 1;
      csr.max_entries <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      @(posedge clock);
   endtask

   // One short random image: noise or the start of a magic, cut before the header ends
   task automatic random_image();
      int    n;
      string mg;
      bit    hdr;
      mg = "070701";
      quiet = ($urandom_range(0, 4) == 0);
      hdr = $urandom_range(0, 1);
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++)
         img.push_back(hdr ? mg[k] : 8'($urandom_range(0, 255)));
      send_image(0);
   endtask

   image_row_type rows[] = '{
      '{"d", 2, M_DIR, 0, 0, 0, 0, 0, 0, cnap_pkg::ST_CLEAN_END},
      '{"TRAILER!!!", 10, M_REG, 0, 0, 0, 0, 0, 0, cnap_pkg::ST_CLEAN_END},
      '{"x", 2, M_REG, 0, 0, 0, 0, 0, 1, cnap_pkg::ST_TOO_SMALL},
      '{"a", 2, M_REG, 0, 0, 1, 0, 0, 110, cnap_pkg::ST_BAD_MAGIC},
      '{"hello", 6, M_REG, 0, 0, 0, 0, 0, 111, cnap_pkg::ST_TRUNC_NAME}
   };

   // Directed images, an empty table, the long stall, then random images
   task automatic run_row(input image_row_type r);
      add_entry(r.mode, r.size, r.nm, r.nsz, r.badmag, 0, r.body);
      if (r.trl) add_entry(0, 0, "TRAILER!!!", 11, 0, 0, 0);
      repeat (r.tail) img.push_back(8'($urandom_range(0, 255)));
      img_last_status = NONE;
      send_image(r.keep);
      settle_down();
      if (r.want != NONE && img_last_status != r.want)
         report("image outcome", img_last_status, r.want);
   endtask

   initial begin
      clock = 0;
      reset = 1;
      req.valid = 0; req.data_byte = 0; req.image_end = 0;
      csr.valid = 0; csr.max_entries = 0;
      capacity = 64;
      quiet = 0; hold_req = 0;
      start_image();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[k]) run_row(rows[k]);

      // zero capacity: the first entry overflows the table
      write_capacity(7'd0);
      run_row('{"a", 2, M_REG, 0, 0, 0, 0, 0, 0, cnap_pkg::ST_TABLE_FULL});
      write_capacity(7'd64);

      // results held back while one-byte images keep coming
      quiet = 1;
      hold_req = 1;
      repeat (12) begin
         img.push_back(8'($urandom_range(0, 255)));
         send_image(0);
      end
      settle_down();
      quiet = 0;

      repeat (25) random_image();
      quiet = 0;
      settle_down();

      $display("covered %0d images, %0d bytes, %0d results of which %0d entries",
               images_sent, bytes_sent, results_seen, entries_seen);
      if (errors == 0) $display("[cpio_newc_archive_parser] OK");
      else $display("[cpio_newc_archive_parser] ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[cpio_newc_archive_parser] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cnap_pkg.sv
rtl/core/cnap_if.sv
rtl/core/cnap_front.sv
rtl/core/cnap_queue.sv
rtl/core/cnap_back.sv
rtl/core/cpio_newc_archive_parser.sv
tb/testbench.sv
